// ===== design/tas_pkg.sv =====
// Shared types, codes and helpers for the tridiagonal apply and solve block.
// No dependencies; used by tas_div, tas_mul and tridiagonal_apply_and_solve.
package tas_pkg;

  localparam int DEF_MAX_ROWS  = 32;
  localparam int DEF_FRAC_BITS = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BC_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BC_VALUE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BC_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BC_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH  = 3'd4;

  // boundary rule codes (codes zero and three act as none)
  localparam logic [1:0] BC_NEUMANN   = 2'd1;
  localparam logic [1:0] BC_DIRICHLET = 2'd2;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_APPLY = 2'd1;
  localparam logic [1:0] REQ_SOLVE = 2'd2;

  localparam logic signed [63:0] S32_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN64 = -64'sd2147483648;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX64) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN64) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/tas_mul.sv =====
// Registered fixed point multiplier: full product shifted right with floor rounding.
// Depends on tas_pkg for the default fraction width.
module tas_mul #(
  parameter int FRAC_BITS = tas_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  logic signed [63:0] prod;

  // exact product, arithmetic shift rounds toward minus infinity
  assign prod = a * b;

  always_ff @(posedge clk) begin
    p <= prod >>> FRAC_BITS;
  end

endmodule

// ===== design/tas_div.sv =====
// Iterative fixed point divider, one quotient bit per cycle, truncating and saturating.
// Depends on tas_pkg for the request and response structs.
module tas_div #(
  parameter int FRAC_BITS = tas_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  tas_pkg::div_req_t req,
  output tas_pkg::div_rsp_t rsp
);

  localparam int NW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic [NW-1:0] MAG_MAX = NW'(32'h7FFF_FFFF);
  localparam logic [NW-1:0] MAG_MIN = NW'(32'h8000_0000);

  logic             active;
  logic             done_r;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    qr;
  logic [NW-1:0]    neg_mag;
  logic [31:0]      rem;
  logic [31:0]      dv;
  logic             neg;
  logic [32:0]      rem_s;
  logic [32:0]      rem_d;
  logic             fits;
  logic [31:0]      num_mag;
  logic [31:0]      den_mag;
  logic signed [31:0] quo_r;
  logic signed [31:0] quo_sat;

  assign num_mag = req.num[31] ? (~req.num + 32'd1) : req.num;
  assign den_mag = req.den[31] ? (~req.den + 32'd1) : req.den;

  // restoring step
  assign rem_s = {rem, qr[NW-1]};
  assign rem_d = rem_s - {1'b0, dv};
  assign fits  = (rem_s >= {1'b0, dv});

  // sign and saturate the magnitude
  assign neg_mag = ~qr + NW'(1);
  always_comb begin
    if (neg) begin
      quo_sat = (qr > MAG_MIN) ? 32'sh8000_0000 : neg_mag[31:0];
    end else begin
      quo_sat = (qr > MAG_MAX) ? 32'sh7FFF_FFFF : qr[31:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NW);
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      qr  <= {num_mag, FRAC_BITS'(0)};
      rem <= '0;
      dv  <= den_mag;
      neg <= req.num[31] ^ req.den[31];
    end else if (active && cnt != '0) begin
      qr  <= {qr[NW-2:0], fits};
      rem <= fits ? rem_d[31:0] : rem_s[31:0];
    end else if (active) begin
      quo_r <= quo_sat;
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.quo  = quo_r;
  end

endmodule

// ===== design/tridiagonal_apply_and_solve.sv =====
// Top level of the tridiagonal apply and solve block: sequencer, coefficient and work memories.
// Depends on tas_pkg, tas_mul and tas_div.

// Load items write one coefficient row; vector elements are buffered until the
// clamped vector length of them have arrived. The final element starts a run
// over the whole vector and the input stalls until the last result has been
// handed to the output register. Apply forms the three products of each row and
// then fixes up the boundary results. Solve runs a forward sweep on the shared
// bit-serial divider, then a back sweep. Each result is read and loaded into the
// output register, which waits while out_stall holds it. A zero pivot ends the
// solve at once and the run carries zeros with div_zero set. Stores need no
// clearing after reset.
module tridiagonal_apply_and_solve #(
  parameter int MAX_ROWS  = tas_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = tas_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      req_type,
  input  logic [4:0]                      row_index,
  input  logic signed [31:0]              below_coef,
  input  logic signed [31:0]              main_coef,
  input  logic signed [31:0]              above_coef,
  input  logic signed [31:0]              vec_value,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_value,
  output logic [4:0]                      out_index,
  output logic                            out_last,
  output logic                            div_zero
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam logic signed [31:0] ONE_Q     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] NEG_ONE_Q = -ONE_Q;

  typedef enum logic [22:0] {
    IDLE  = 23'h000001,
    A_RD0 = 23'h000002,
    A_RD1 = 23'h000004,
    A_RD2 = 23'h000008,
    A_RD3 = 23'h000010,
    A_M3  = 23'h000020,
    A_M4  = 23'h000040,
    F_LRD = 23'h000080,
    F_LWR = 23'h000100,
    F_URD = 23'h000200,
    F_UWR = 23'h000400,
    S_RD  = 23'h000800,
    S_LAT = 23'h001000,
    S_D1  = 23'h002000,
    S_MA  = 23'h004000,
    S_MB  = 23'h008000,
    S_NUM = 23'h010000,
    S_D2  = 23'h020000,
    B_RD  = 23'h040000,
    B_MUL = 23'h080000,
    B_WR  = 23'h100000,
    O_RD  = 23'h200000,
    O_LD  = 23'h400000
  } state_t;

  state_t state;

  // configuration registers
  logic [1:0]         lbc_type;
  logic signed [31:0] lbc_value;
  logic [1:0]         ubc_type;
  logic signed [31:0] ubc_value;
  logic [5:0]         vec_len;

  // sequencing
  logic [CW-1:0] elem_cnt;
  logic [CW-1:0] j;
  logic          dz;
  logic [CW-1:0] nlen;
  logic [CW-1:0] n_last;
  logic          j_first;
  logic          j_last;
  logic          accept;
  logic          is_elem;
  logic          row_ok;
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] cnt_inc;
  logic          out_load;

  // working registers
  logic signed [31:0] lo_r, mi_r, up_r, rhs_r;
  logic signed [31:0] vm1, v0, vp1;
  logic signed [63:0] acc;
  logic signed [31:0] bet, up_prev, r_prev, ratio_r;

  // memories and ports
  logic [95:0] coef_mem [MAX_ROWS];
  logic [31:0] vec_mem  [MAX_ROWS];
  logic [31:0] ratio_mem[MAX_ROWS];
  logic [31:0] res_mem  [MAX_ROWS];
  logic [95:0] coef_rd;
  logic [31:0] vec_rd, ratio_rd, res_rd;
  logic          coef_we, coef_re, vec_we, vec_re, ratio_we, ratio_re, res_we, res_re;
  logic [AW-1:0] coef_wa, vec_wa, vec_ra, res_wa, res_ra;
  logic [31:0]   res_wd;

  // effective row and right-hand side
  logic signed [31:0] lo_e, mi_e, up_e, rhs_e;

  // arithmetic units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] p;
  tas_pkg::div_req_t  div_req;
  tas_pkg::div_rsp_t  div_rsp;
  logic signed [31:0] bet_nx;
  logic signed [31:0] back_val;

  tas_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  tas_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // active length clamped to the supported range
  always_comb begin
    if (vec_len < 6'd2) begin
      nlen = CW'(2);
    end else if (int'(vec_len) > MAX_ROWS) begin
      nlen = CW'(MAX_ROWS);
    end else begin
      nlen = CW'(vec_len);
    end
  end

  assign n_last   = nlen - CW'(1);
  assign j_first  = (j == '0);
  assign j_last   = (j == n_last);
  assign cfg_ready = 1'b1;
  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_elem  = (req_type == tas_pkg::REQ_APPLY) || (req_type == tas_pkg::REQ_SOLVE);
  assign row_ok   = (int'(row_index) < MAX_ROWS);
  assign cnt_eff  = (elem_cnt >= nlen) ? '0 : elem_cnt;
  assign cnt_inc  = cnt_eff + CW'(1);
  assign out_load = (state == O_LD) && (!out_valid || !out_stall);

  // boundary rules override the end rows at use time
  always_comb begin
    lo_e  = coef_rd[95:64];
    mi_e  = coef_rd[63:32];
    up_e  = coef_rd[31:0];
    rhs_e = vec_rd;
    if (j_first) begin
      if (lbc_type == tas_pkg::BC_NEUMANN) begin
        mi_e = NEG_ONE_Q;
        up_e = ONE_Q;
      end else if (lbc_type == tas_pkg::BC_DIRICHLET) begin
        mi_e = ONE_Q;
        up_e = '0;
      end
      if (lbc_type == tas_pkg::BC_NEUMANN || lbc_type == tas_pkg::BC_DIRICHLET) begin
        rhs_e = lbc_value;
      end
    end
    if (j_last) begin
      if (ubc_type == tas_pkg::BC_NEUMANN) begin
        lo_e = NEG_ONE_Q;
        mi_e = ONE_Q;
      end else if (ubc_type == tas_pkg::BC_DIRICHLET) begin
        lo_e = '0;
        mi_e = ONE_Q;
      end
      if (ubc_type == tas_pkg::BC_NEUMANN || ubc_type == tas_pkg::BC_DIRICHLET) begin
        rhs_e = ubc_value;
      end
    end
  end

  assign bet_nx   = tas_pkg::sat32(64'(mi_r) - p);
  assign back_val = tas_pkg::sat32(64'($signed(res_rd)) - p);

  // memory, multiplier and divider control per state
  always_comb begin
    coef_we  = 1'b0;
    coef_re  = 1'b0;
    vec_we   = 1'b0;
    vec_re   = 1'b0;
    ratio_we = 1'b0;
    ratio_re = 1'b0;
    res_we   = 1'b0;
    res_re   = 1'b0;
    coef_wa  = AW'(row_index);
    vec_wa   = AW'(cnt_eff);
    vec_ra   = AW'(j);
    res_wa   = AW'(j);
    res_ra   = AW'(j);
    res_wd   = '0;
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;
    case (state)
      IDLE: begin
        coef_we = accept && (req_type == tas_pkg::REQ_LOAD) && row_ok;
        vec_we  = accept && is_elem;
      end
      A_RD0: begin
        coef_re = 1'b1;
        vec_re  = 1'b1;
        vec_ra  = AW'(j - CW'(1));
      end
      A_RD1: begin
        vec_re = 1'b1;
      end
      A_RD2: begin
        vec_re = 1'b1;
        vec_ra = AW'(j + CW'(1));
        mul_a  = lo_r;
        mul_b  = vm1;
      end
      A_RD3: begin
        mul_a = mi_r;
        mul_b = v0;
      end
      A_M3: begin
        mul_a = up_r;
        mul_b = vp1;
      end
      A_M4: begin
        res_we = 1'b1;
        res_wd = tas_pkg::sat32(acc + p);
      end
      F_LRD: begin
        res_re = 1'b1;
        res_ra = AW'(1);
      end
      F_LWR: begin
        res_we = (lbc_type == tas_pkg::BC_NEUMANN) || (lbc_type == tas_pkg::BC_DIRICHLET);
        res_wa = '0;
        res_wd = (lbc_type == tas_pkg::BC_NEUMANN) ?
                 tas_pkg::sat32(64'($signed(res_rd)) + 64'(lbc_value)) : lbc_value;
      end
      F_URD: begin
        res_re = 1'b1;
        res_ra = AW'(n_last - CW'(1));
      end
      F_UWR: begin
        res_we = (ubc_type == tas_pkg::BC_NEUMANN) || (ubc_type == tas_pkg::BC_DIRICHLET);
        res_wa = AW'(n_last);
        res_wd = (ubc_type == tas_pkg::BC_NEUMANN) ?
                 tas_pkg::sat32(64'($signed(res_rd)) + 64'(ubc_value)) : ubc_value;
      end
      S_RD: begin
        coef_re = 1'b1;
        vec_re  = 1'b1;
      end
      S_LAT: begin
        if (j_first) begin
          div_req.start = (mi_e != '0);
          div_req.num   = rhs_e;
          div_req.den   = mi_e;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = up_prev;
          div_req.den   = bet;
        end
      end
      S_D1: begin
        ratio_we = div_rsp.done;
      end
      S_MA: begin
        mul_a = lo_r;
        mul_b = ratio_r;
      end
      S_MB: begin
        mul_a = lo_r;
        mul_b = r_prev;
      end
      S_NUM: begin
        div_req.start = 1'b1;
        div_req.num   = tas_pkg::sat32(64'(rhs_r) - p);
        div_req.den   = bet;
      end
      S_D2: begin
        res_we = div_rsp.done;
        res_wd = div_rsp.quo;
      end
      B_RD: begin
        ratio_re = 1'b1;
        res_re   = 1'b1;
        res_ra   = AW'(j - CW'(1));
      end
      B_MUL: begin
        mul_a = ratio_rd;
        mul_b = r_prev;
      end
      B_WR: begin
        res_we = 1'b1;
        res_wa = AW'(j - CW'(1));
        res_wd = back_val;
      end
      O_RD: begin
        res_re = 1'b1;
      end
      O_LD: begin
      end
      default: begin
      end
    endcase
  end

  // coefficient memory: one row of three coefficients per entry
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_wa] <= {below_coef, main_coef, above_coef};
    if (coef_re) coef_rd <= coef_mem[AW'(j)];
  end

  // vector buffer
  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_wa] <= vec_value;
    if (vec_re) vec_rd <= vec_mem[vec_ra];
  end

  // forward sweep ratios
  always_ff @(posedge clk) begin
    if (ratio_we) ratio_mem[AW'(j)] <= div_rsp.quo;
    if (ratio_re) ratio_rd <= ratio_mem[AW'(j)];
  end

  // result vector
  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    if (res_re) res_rd <= res_mem[res_ra];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lbc_type  <= '0;
      lbc_value <= '0;
      ubc_type  <= '0;
      ubc_value <= '0;
      vec_len   <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tas_pkg::CFG_LOWER_BC_TYPE:  lbc_type  <= cfg_data[1:0];
        tas_pkg::CFG_LOWER_BC_VALUE: lbc_value <= cfg_data;
        tas_pkg::CFG_UPPER_BC_TYPE:  ubc_type  <= cfg_data[1:0];
        tas_pkg::CFG_UPPER_BC_VALUE: ubc_value <= cfg_data;
        tas_pkg::CFG_VECTOR_LENGTH:  vec_len   <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      j        <= '0;
      dz       <= 1'b0;
      elem_cnt <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (accept && is_elem) begin
            if (cnt_inc < nlen) begin
              elem_cnt <= cnt_inc;
            end else begin
              elem_cnt <= '0;
              j        <= '0;
              dz       <= 1'b0;
              state    <= (req_type == tas_pkg::REQ_APPLY) ? A_RD0 : S_RD;
            end
          end
        end
        A_RD0: state <= A_RD1;
        A_RD1: state <= A_RD2;
        A_RD2: state <= A_RD3;
        A_RD3: state <= A_M3;
        A_M3:  state <= A_M4;
        A_M4: begin
          if (j_last) begin
            state <= F_LRD;
          end else begin
            j     <= j + CW'(1);
            state <= A_RD0;
          end
        end
        F_LRD: state <= F_LWR;
        F_LWR: state <= F_URD;
        F_URD: state <= F_UWR;
        F_UWR: begin
          j     <= '0;
          state <= O_RD;
        end
        S_RD: state <= S_LAT;
        S_LAT: begin
          if (!j_first) begin
            state <= S_D1;
          end else if (mi_e == '0) begin
            dz    <= 1'b1;
            j     <= '0;
            state <= O_RD;
          end else begin
            state <= S_D2;
          end
        end
        S_D1: begin
          if (div_rsp.done) state <= S_MA;
        end
        S_MA: state <= S_MB;
        S_MB: begin
          if (bet_nx == '0) begin
            dz    <= 1'b1;
            j     <= '0;
            state <= O_RD;
          end else begin
            state <= S_NUM;
          end
        end
        S_NUM: state <= S_D2;
        S_D2: begin
          if (div_rsp.done) begin
            if (j_last) begin
              state <= B_RD;
            end else begin
              j     <= j + CW'(1);
              state <= S_RD;
            end
          end
        end
        B_RD:  state <= B_MUL;
        B_MUL: state <= B_WR;
        B_WR: begin
          if (j == CW'(1)) begin
            j     <= '0;
            state <= O_RD;
          end else begin
            j     <= j - CW'(1);
            state <= B_RD;
          end
        end
        O_RD: state <= O_LD;
        O_LD: begin
          if (out_load) begin
            if (j_last) begin
              state <= IDLE;
            end else begin
              j     <= j + CW'(1);
              state <= O_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // working registers of the sweeps
  always_ff @(posedge clk) begin
    case (state)
      A_RD1: begin
        lo_r <= lo_e;
        mi_r <= mi_e;
        up_r <= up_e;
        vm1  <= j_first ? '0 : $signed(vec_rd);
      end
      A_RD2: v0 <= vec_rd;
      A_RD3: begin
        acc <= p;
        vp1 <= j_last ? '0 : $signed(vec_rd);
      end
      A_M3: acc <= acc + p;
      S_LAT: begin
        lo_r  <= lo_e;
        mi_r  <= mi_e;
        up_r  <= up_e;
        rhs_r <= rhs_e;
        if (j_first) bet <= mi_e;
      end
      S_D1: begin
        if (div_rsp.done) ratio_r <= div_rsp.quo;
      end
      S_MB: bet <= bet_nx;
      S_D2: begin
        if (div_rsp.done) begin
          r_prev  <= div_rsp.quo;
          up_prev <= up_r;
        end
      end
      B_WR: r_prev <= back_val;
      default: begin
      end
    endcase
  end

  // output register, loaded while empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= dz ? '0 : $signed(res_rd);
      out_index <= 5'(j);
      out_last  <= j_last;
      div_zero  <= dz;
    end
  end

  // divider results only arrive while the sequencer waits on them
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_D1 || state == S_D2))
    else $error("divider finished outside a wait state");

  // a run that met a zero pivot writes no further results
  a_dz_no_write: assert property (@(posedge clk) disable iff (rst)
    res_we |-> !dz)
    else $error("result write after zero pivot");

  // a loaded result is presented on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule
